[hw/rtl/cle_pkg.sv]
// ---------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Command codes passed from the front to the back, result kinds and the
// control characters that the editor recognizes.
// ---------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

	// result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// input operations
	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// last step of the three-result commands
	localparam logic [1:0] STEP_LAST = 2'd2;

	typedef enum logic [2:0] {
		CMD_CHAR,
		CMD_ERASE,
		CMD_CR_ECHO,
		CMD_DONE,
		CMD_READ
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t  code;
		logic [7:0] data;
		logic [7:0] len;
	} cmd_t;

endpackage

`default_nettype wire

[hw/rtl/cle_in_if.sv]
// ---------------------------------------------------------------------------
// cle_in_if: input item channel of the console line editor
// Valid/ready channel carrying one console byte or one line store read.
// ---------------------------------------------------------------------------
`default_nettype none

interface cle_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, op, rx_byte, read_index, input ready);
	modport sink (input valid, op, rx_byte, read_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/cle_out_if.sv]
// ---------------------------------------------------------------------------
// cle_out_if: result channel of the console line editor
// Valid/ready channel carrying echo bytes, line-complete and read results.
// ---------------------------------------------------------------------------
`default_nettype none

interface cle_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [7:0] line_length;
	logic       last;

	modport source (output valid, kind, out_byte, line_length, last, input ready);
	modport sink (input valid, kind, out_byte, line_length, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/cle_front.sv]
// ---------------------------------------------------------------------------
// cle_front: accepts and classifies items, keeps the line state
// Holds the line store, fill count, echo flag and completed length, and
// turns each item into at most one command for the back.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_front #(
	parameter int LINE_MAX = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	cle_in_if.sink           item,
	output logic             push,
	output cle_pkg::cmd_t    push_cmd,
	input  wire              q_full
);

	localparam int LINE_CAP = ((LINE_MAX - 1) < 255) ? (LINE_MAX - 1) : 255;
	localparam int DEPTH    = LINE_CAP;
	localparam int AW       = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	logic [7:0] fill_q;
	logic       echo_q;
	logic [7:0] done_len_q;

	logic                valid_s1;
	cle_pkg::cmd_code_t  code_s1;
	logic [7:0]          data_s1;
	logic [7:0]          len_s1;
	logic                zero_s1;
	logic [7:0]          rd_byte_s1;

	logic accept;
	logic is_cr, is_skip, is_erase, can_erase, can_store, marker;
	logic store_echo;

	assign item.ready = !valid_s1 || !q_full;
	assign accept     = item.valid && item.ready;

	always_comb begin
		is_cr      = item.rx_byte == cle_pkg::CH_CR;
		is_skip    = item.rx_byte == cle_pkg::CH_LF || item.rx_byte == cle_pkg::CH_NUL;
		is_erase   = item.rx_byte == cle_pkg::CH_BS || item.rx_byte == cle_pkg::CH_DEL;
		can_erase  = fill_q != 8'd0;
		can_store  = fill_q < 8'(LINE_CAP);
		marker     = fill_q == 8'd0 &&
			(item.rx_byte == cle_pkg::CH_S || item.rx_byte == cle_pkg::CH_COLON);
		store_echo = echo_q && !marker;
	end

	// line state and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= 8'd0;
			echo_q     <= 1'b1;
			done_len_q <= 8'd0;
			valid_s1   <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (item.op == cle_pkg::OP_READ) begin
					valid_s1 <= 1'b1;
				end else if (is_cr) begin
					valid_s1   <= 1'b1;
					done_len_q <= fill_q;
					fill_q     <= 8'd0;
					echo_q     <= 1'b1;
				end else if (is_skip) begin
					valid_s1 <= 1'b0;
				end else if (is_erase) begin
					if (can_erase) begin
						fill_q   <= fill_q - 8'd1;
						valid_s1 <= echo_q;
					end
				end else if (can_store) begin
					fill_q   <= fill_q + 8'd1;
					echo_q   <= store_echo;
					valid_s1 <= store_echo;
				end
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= item.rx_byte;
			len_s1  <= 8'd0;
			zero_s1 <= 1'b0;
			if (item.op == cle_pkg::OP_READ) begin
				code_s1 <= cle_pkg::CMD_READ;
				len_s1  <= done_len_q;
				zero_s1 <= !(item.read_index < done_len_q);
			end else if (is_cr) begin
				code_s1 <= echo_q ? cle_pkg::CMD_CR_ECHO : cle_pkg::CMD_DONE;
				len_s1  <= fill_q;
			end else if (is_erase) begin
				code_s1 <= cle_pkg::CMD_ERASE;
			end else begin
				code_s1 <= cle_pkg::CMD_CHAR;
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (accept && item.op == cle_pkg::OP_RX && !is_cr && !is_skip && !is_erase &&
			can_store) begin
			mem[AW'(fill_q)] <= item.rx_byte;
		end
		if (accept && item.op == cle_pkg::OP_READ) begin
			rd_byte_s1 <= mem[AW'(item.read_index)];
		end
	end

	assign push = valid_s1 && !q_full;

	always_comb begin
		push_cmd.code = code_s1;
		push_cmd.len  = len_s1;
		if (code_s1 == cle_pkg::CMD_READ) begin
			push_cmd.data = zero_s1 ? 8'd0 : rd_byte_s1;
		end else begin
			push_cmd.data = data_s1;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/cle_queue.sv]
// ---------------------------------------------------------------------------
// cle_queue: short command queue between front and back
// Register FIFO; head is visible while not empty.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  cle_pkg::cmd_t       push_cmd,
	output logic                full,
	input  wire                 pop,
	output cle_pkg::cmd_t       head,
	output logic                head_valid
);

	cle_pkg::cmd_t entry_q [cle_pkg::QUEUE_DEPTH];

	logic [cle_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [cle_pkg::QCNT_W-1:0] count_q;

	assign full       = count_q == cle_pkg::QCNT_W'(cle_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/cle_back.sv]
// ---------------------------------------------------------------------------
// cle_back: carries out commands and drives the result channel
// Expands each command into one to three results, one per cycle while the
// result channel is ready, into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_back (
	input  wire             clk,
	input  wire             arst_n,
	input  cle_pkg::cmd_t   head,
	input  wire             head_valid,
	output logic            pop,
	cle_out_if.source       result
);

	logic [1:0] step_q;
	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [7:0] len_q;
	logic       last_q;

	logic       advance, last_step;
	logic [1:0] kind_d;
	logic [7:0] byte_d, len_d;

	assign advance = head_valid && (!valid_q || result.ready);
	assign pop     = advance && last_step;

	always_comb begin
		kind_d    = cle_pkg::KIND_ECHO;
		byte_d    = head.data;
		len_d     = 8'd0;
		last_step = 1'b1;
		case (head.code)
			cle_pkg::CMD_CHAR: begin
				byte_d = head.data;
			end
			cle_pkg::CMD_ERASE: begin
				byte_d    = (step_q == 2'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
				last_step = step_q == cle_pkg::STEP_LAST;
			end
			cle_pkg::CMD_CR_ECHO: begin
				last_step = step_q == cle_pkg::STEP_LAST;
				if (step_q == 2'd0) begin
					byte_d = cle_pkg::CH_CR;
				end else if (step_q == 2'd1) begin
					byte_d = cle_pkg::CH_LF;
				end else begin
					kind_d = cle_pkg::KIND_DONE;
					byte_d = 8'd0;
					len_d  = head.len;
				end
			end
			cle_pkg::CMD_DONE: begin
				kind_d = cle_pkg::KIND_DONE;
				byte_d = 8'd0;
				len_d  = head.len;
			end
			cle_pkg::CMD_READ: begin
				kind_d = cle_pkg::KIND_READ;
				len_d  = head.len;
			end
			default: begin
				kind_d = cle_pkg::KIND_ECHO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else begin
			if (result.ready) begin
				valid_q <= 1'b0;
			end
			if (advance) begin
				valid_q <= 1'b1;
				step_q  <= last_step ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			len_q  <= len_d;
			last_q <= last_step;
		end
	end

	assign result.valid       = valid_q;
	assign result.kind        = kind_q;
	assign result.out_byte    = byte_q;
	assign result.line_length = len_q;
	assign result.last        = last_q;

endmodule

`default_nettype wire

[hw/rtl/console_line_editor.sv]
// ---------------------------------------------------------------------------
// console_line_editor: serial console line editor with echo
// Edits received console bytes into one line and answers line store reads.
// ---------------------------------------------------------------------------
// Usage:
//   item   - valid/ready input; op selects a received byte (rx_byte) or a
//            read of the completed line (read_index)
//   result - valid/ready output; echo bytes, line-complete with length,
//            read data; last marks the final result of an item
// Path: an item passes the front stage register, the command queue and the
//   output register before its first result.
// Throughput: one result per cycle while result.ready is high; an echoed erase
//   or a carriage return with echo gives three results, other items at most one. An item is accepted every cycle
//   while the four-entry command queue has room; the back's result
//   sequencer sets the pace.
// Reset: line empty, echo on, completed length zero; queue and output empty.
//   The line store is not cleared; only written entries reach a read result.
// Stall: a stalled result holds; the queue fills and then item.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module console_line_editor #(
	parameter int LINE_MAX = 256
) (
	input  wire        clk,
	input  wire        arst_n,
	cle_in_if.sink     item,
	cle_out_if.source  result
);

	logic          push, q_full, pop, head_valid;
	cle_pkg::cmd_t push_cmd, head;

	cle_front #(
		.LINE_MAX (LINE_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	cle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	cle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire

[hw/rtl/cle_checker.sv]
// ---------------------------------------------------------------------------
// cle_checker: port-level checks of the console line editor
// Watches the result channel; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       valid,
	input wire       ready,
	input wire [1:0] kind,
	input wire [7:0] out_byte,
	input wire [7:0] line_length,
	input wire       last
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(kind) && $stable(out_byte))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> kind == cle_pkg::KIND_ECHO || kind == cle_pkg::KIND_DONE ||
			kind == cle_pkg::KIND_READ)
		else $error("unknown result kind");

	a_echo_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == cle_pkg::KIND_ECHO |-> line_length == 8'd0)
		else $error("echo result with nonzero length");

	// line complete always ends its item
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == cle_pkg::KIND_DONE |-> out_byte == 8'd0 && last)
		else $error("bad line-complete result");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == cle_pkg::KIND_READ |-> last)
		else $error("read result not last");

endmodule

bind console_line_editor cle_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.kind        (result.kind),
	.out_byte    (result.out_byte),
	.line_length (result.line_length),
	.last        (result.last)
);

`default_nettype wire
